### sv/spta_pkg.sv
// ----------------------------------------------------------------------------
// Sparse polynomial term accumulator package
// Shared widths, table entry and memory request types, op and status codes.
// ----------------------------------------------------------------------------
package spta_pkg;

	localparam int MAX_TERMS  = 32;
	localparam int IDX_W      = $clog2(MAX_TERMS);
	localparam int CNT_W      = $clog2(MAX_TERMS + 1);
	localparam int COEFF_BITS = 32;
	localparam int POWER_BITS = 16;

	typedef logic signed [COEFF_BITS-1:0] coef_t;
	typedef logic signed [POWER_BITS-1:0] power_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	localparam coef_t COEF_MIN = {1'b1, {(COEFF_BITS-1){1'b0}}};

	typedef struct packed {
		coef_t  coef;
		power_t power;
	} entry_t;

	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		logic   re;
		idx_t   raddr;
	} mem_req_t;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_SUB   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_MERGED  = 3'd1,
		ST_REMOVED = 3'd2,
		ST_ZERO    = 3'd3,
		ST_FULL    = 3'd4,
		ST_TERM    = 3'd5,
		ST_EMPTY   = 3'd6,
		ST_CLEARED = 3'd7
	} status_t;

endpackage

### sv/spta_mem.sv
// ----------------------------------------------------------------------------
// Term table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module spta_mem (
	input  logic              clk,
	input  spta_pkg::mem_req_t req,
	output spta_pkg::entry_t   rdata
);
	import spta_pkg::*;

	entry_t mem [MAX_TERMS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

### sv/sparse_polynomial_term_accumulator.sv
// ----------------------------------------------------------------------------
// Sparse polynomial term accumulator
// Holds a sparse polynomial as a table of nonzero terms sorted by power in a
// synchronous memory, and adds, subtracts, reads out or clears terms.
//
//   Channel   Handshake            Payload
//   -------   ------------------   -----------------------------------------
//   command   start, busy          op, coefficient, power
//   result    valid (one cycle)    status, term_coefficient, term_power,
//                                  term_count, is_empty, degree, last
//
// An add or subtract reads and compares entries in order of power, then
// either merges into a matching entry or shifts the higher entries up and
// writes the new entry, and ends with a degree refresh; a removal also
// shifts the entries above it down.
// A full-table drop answers right after the scan. A read out emits each term
// in turn. A rejected term, a clear and a read out of an empty table answer
// in the next cycle. Reset empties the table; the memory itself is not
// cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_accumulator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  spta_pkg::coef_t       coefficient,
	input  spta_pkg::power_t      power,
	output logic                  valid,
	output logic [2:0]            status,
	output spta_pkg::coef_t       term_coefficient,
	output spta_pkg::power_t      term_power,
	output spta_pkg::cnt_t        term_count,
	output logic                  is_empty,
	output spta_pkg::power_t      degree,
	output logic                  last
);
	import spta_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SH_RD,
		S_SH_WR,
		S_MERGE,
		S_RM_RD,
		S_RM_WR,
		S_DEG_RD,
		S_DEG_WAIT,
		S_RO_RD,
		S_RO_EMIT
	} state_t;

	state_t   state_q;
	cnt_t     held_q;
	power_t   degree_q;
	idx_t     idx_q;
	idx_t     pos_q;
	coef_t    coef_q;
	power_t   pow_q;
	coef_t    sum_q;
	logic     rm_q;
	status_t  st_q;

	logic     valid_q;
	status_t  out_status_q;
	coef_t    out_coef_q;
	power_t   out_power_q;
	cnt_t     out_count_q;
	logic     out_empty_q;
	power_t   out_degree_q;
	logic     out_last_q;

	mem_req_t req;
	entry_t   rdata;
	coef_t    c_eff;
	coef_t    sum;
	logic     ovf;

	spta_mem u_mem (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign busy = (state_q != S_IDLE);

	always_comb begin
		if (op_t'(op) == OP_SUB) begin
			c_eff = (coefficient == COEF_MIN) ? '0 : -coefficient;
		end else begin
			c_eff = coefficient;
		end
	end

	assign sum = rdata.coef + coef_q;
	assign ovf = (rdata.coef[COEFF_BITS-1] == coef_q[COEFF_BITS-1]) &&
		(sum[COEFF_BITS-1] != rdata.coef[COEFF_BITS-1]);

	always_comb begin
		req = '0;
		case (state_q)
			S_SCAN_RD: begin
				req.re    = 1'b1;
				req.raddr = idx_q;
			end
			S_SH_RD: begin
				if (idx_q == pos_q) begin
					req.we    = 1'b1;
					req.waddr = pos_q;
					req.wdata = '{coef: coef_q, power: pow_q};
				end else begin
					req.re    = 1'b1;
					req.raddr = idx_q - idx_t'(1);
				end
			end
			S_SH_WR, S_RM_WR: begin
				req.we    = 1'b1;
				req.waddr = idx_q;
				req.wdata = rdata;
			end
			S_MERGE: begin
				if (!rm_q) begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = '{coef: sum_q, power: pow_q};
				end
			end
			S_RM_RD: begin
				if (CNT_W'(idx_q) + CNT_W'(1) != held_q) begin
					req.re    = 1'b1;
					req.raddr = idx_q + idx_t'(1);
				end
			end
			S_DEG_RD: begin
				if (held_q != '0) begin
					req.re    = 1'b1;
					req.raddr = idx_t'(held_q - CNT_W'(1));
				end
			end
			S_RO_RD: begin
				req.re    = 1'b1;
				req.raddr = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			held_q       <= '0;
			degree_q     <= '0;
			valid_q      <= 1'b0;
			idx_q        <= '0;
			pos_q        <= '0;
			coef_q       <= '0;
			pow_q        <= '0;
			sum_q        <= '0;
			rm_q         <= 1'b0;
			st_q         <= ST_ADDED;
			out_status_q <= ST_ADDED;
			out_coef_q   <= '0;
			out_power_q  <= '0;
			out_count_q  <= '0;
			out_empty_q  <= 1'b1;
			out_degree_q <= '0;
			out_last_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op_t'(op))
							OP_READ: begin
								if (held_q == '0) begin
									valid_q      <= 1'b1;
									out_status_q <= ST_EMPTY;
									out_coef_q   <= '0;
									out_power_q  <= '0;
									out_count_q  <= held_q;
									out_empty_q  <= 1'b1;
									out_degree_q <= degree_q;
									out_last_q   <= 1'b1;
								end else begin
									idx_q   <= idx_t'(held_q - CNT_W'(1));
									state_q <= S_RO_RD;
								end
							end
							OP_CLEAR: begin
								held_q       <= '0;
								degree_q     <= '0;
								valid_q      <= 1'b1;
								out_status_q <= ST_CLEARED;
								out_coef_q   <= '0;
								out_power_q  <= '0;
								out_count_q  <= '0;
								out_empty_q  <= 1'b1;
								out_degree_q <= '0;
								out_last_q   <= 1'b1;
							end
							default: begin
								coef_q <= c_eff;
								pow_q  <= power;
								if (c_eff == '0) begin
									valid_q      <= 1'b1;
									out_status_q <= ST_ZERO;
									out_coef_q   <= '0;
									out_power_q  <= '0;
									out_count_q  <= held_q;
									out_empty_q  <= (held_q == '0);
									out_degree_q <= degree_q;
									out_last_q   <= 1'b1;
								end else if (held_q == '0) begin
									pos_q   <= '0;
									idx_q   <= '0;
									state_q <= S_SH_RD;
								end else begin
									idx_q   <= '0;
									state_q <= S_SCAN_RD;
								end
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (rdata.power == pow_q) begin
						sum_q   <= sum;
						rm_q    <= ovf || (sum == '0);
						state_q <= S_MERGE;
					end else if (rdata.power < pow_q &&
						CNT_W'(idx_q) + CNT_W'(1) != held_q) begin
						idx_q   <= idx_q + idx_t'(1);
						state_q <= S_SCAN_RD;
					end else if (held_q == CNT_W'(MAX_TERMS)) begin
						valid_q      <= 1'b1;
						out_status_q <= ST_FULL;
						out_coef_q   <= '0;
						out_power_q  <= '0;
						out_count_q  <= held_q;
						out_empty_q  <= 1'b0;
						out_degree_q <= degree_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						pos_q   <= (rdata.power < pow_q) ? idx_q + idx_t'(1) : idx_q;
						idx_q   <= idx_t'(held_q);
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					if (idx_q == pos_q) begin
						held_q  <= held_q + CNT_W'(1);
						st_q    <= ST_ADDED;
						state_q <= S_DEG_RD;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					idx_q   <= idx_q - idx_t'(1);
					state_q <= S_SH_RD;
				end
				S_MERGE: begin
					if (rm_q) begin
						st_q    <= ST_REMOVED;
						state_q <= S_RM_RD;
					end else begin
						st_q    <= ST_MERGED;
						state_q <= S_DEG_RD;
					end
				end
				S_RM_RD: begin
					if (CNT_W'(idx_q) + CNT_W'(1) == held_q) begin
						held_q  <= held_q - CNT_W'(1);
						state_q <= S_DEG_RD;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					idx_q   <= idx_q + idx_t'(1);
					state_q <= S_RM_RD;
				end
				S_DEG_RD: begin
					if (held_q == '0) begin
						degree_q     <= '0;
						valid_q      <= 1'b1;
						out_status_q <= st_q;
						out_coef_q   <= '0;
						out_power_q  <= '0;
						out_count_q  <= held_q;
						out_empty_q  <= 1'b1;
						out_degree_q <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_DEG_WAIT;
					end
				end
				S_DEG_WAIT: begin
					degree_q     <= rdata.power;
					valid_q      <= 1'b1;
					out_status_q <= st_q;
					out_coef_q   <= '0;
					out_power_q  <= '0;
					out_count_q  <= held_q;
					out_empty_q  <= 1'b0;
					out_degree_q <= rdata.power;
					out_last_q   <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_RO_RD: begin
					state_q <= S_RO_EMIT;
				end
				S_RO_EMIT: begin
					valid_q      <= 1'b1;
					out_status_q <= ST_TERM;
					out_coef_q   <= rdata.coef;
					out_power_q  <= rdata.power;
					out_count_q  <= held_q;
					out_empty_q  <= 1'b0;
					out_degree_q <= degree_q;
					out_last_q   <= (idx_q == '0);
					if (idx_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q - idx_t'(1);
						state_q <= S_RO_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign valid            = valid_q;
	assign status           = out_status_q;
	assign term_coefficient = out_coef_q;
	assign term_power       = out_power_q;
	assign term_count       = out_count_q;
	assign is_empty         = out_empty_q;
	assign degree           = out_degree_q;
	assign last             = out_last_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> term_count <= CNT_W'(MAX_TERMS))
		else $error("term count beyond table size");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (is_empty == (term_count == '0)))
		else $error("empty flag disagrees with term count");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status != ST_TERM) |-> last)
		else $error("single result item without last");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> busy)
		else $error("table written while idle");
`endif

endmodule
